>>> rtl/v3a_pkg.sv
`timescale 1ns / 1ps
// Shared operation codes and control bundle for the vector fixed-point ALU.
package v3a_pkg;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_SCALE = 3'd2,
        KIND_DOT   = 3'd3,
        KIND_NORM  = 3'd4,
        KIND_UNIT  = 3'd5
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic       ovf;
        logic       zn;
        logic [2:0] neg;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

>>> rtl/v3a_sat.sv
`timescale 1ns / 1ps
// Saturation of a signed value to the output word width.
module v3a_sat #(
    parameter int IW = 33,
    parameter int OW = 32
) (
    input  logic signed [IW-1:0] i_val,
    output logic signed [OW-1:0] o_val,
    output logic                 o_ovf
);

    generate
        if (IW > OW) begin : g_clip
            logic hi_ones;
            logic hi_zeros;
            assign hi_ones  = &i_val[IW-1:OW-1];
            assign hi_zeros = ~|i_val[IW-1:OW-1];
            assign o_ovf    = ~(hi_ones | hi_zeros);
            assign o_val    = o_ovf ? (i_val[IW-1] ? {1'b1, {(OW-1){1'b0}}}
                                                   : {1'b0, {(OW-1){1'b1}}})
                                    : i_val[OW-1:0];
        end else begin : g_ext
            assign o_ovf = 1'b0;
            assign o_val = OW'(i_val);
        end
    endgenerate

endmodule

>>> rtl/v3a_front.sv
`timescale 1ns / 1ps
// Front pipeline: split multipliers, product sums, rounding and saturation.
module v3a_front
    import v3a_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [2:0]                     i_kind,
    input  logic signed [DATA_WIDTH-1:0]   i_ax,
    input  logic signed [DATA_WIDTH-1:0]   i_ay,
    input  logic signed [DATA_WIDTH-1:0]   i_az,
    input  logic signed [DATA_WIDTH-1:0]   i_bx,
    input  logic signed [DATA_WIDTH-1:0]   i_by,
    input  logic signed [DATA_WIDTH-1:0]   i_bz,
    input  logic signed [DATA_WIDTH-1:0]   i_scale_factor,
    output t_ctl                           o_ctl,
    output logic signed [DATA_WIDTH-1:0]   o_rx,
    output logic signed [DATA_WIDTH-1:0]   o_ry,
    output logic signed [DATA_WIDTH-1:0]   o_rz,
    output logic signed [DATA_WIDTH-1:0]   o_sc,
    output logic [3*DATA_WIDTH-1:0]        o_absa,
    output logic [2*DATA_WIDTH-1:0]        o_sq
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int LW = W / 2;
    localparam int HW = W - LW;
    localparam logic signed [2*W:0]   HALF_P = {{(2*W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [2*W+1:0] HALF_D = {{(2*W+2-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    logic signed [W-1:0] a_v [3];
    logic signed [W-1:0] b_v [3];

    logic                    r1_valid;
    t_kind                   r1_kind;
    logic signed [2*HW-1:0]  r1_hh [3];
    logic signed [W:0]       r1_hl [3];
    logic signed [W:0]       r1_lh [3];
    logic [2*LW-1:0]         r1_ll [3];
    logic signed [W:0]       r1_as [3];
    logic [W-1:0]            r1_abs [3];
    logic [2:0]              r1_neg;

    logic                    r2_valid;
    t_kind                   r2_kind;
    logic signed [2*W-1:0]   r2_p [3];
    logic signed [W:0]       r2_as [3];
    logic [W-1:0]            r2_abs [3];
    logic [2:0]              r2_neg;

    logic                    r3_valid;
    t_kind                   r3_kind;
    logic signed [2*W-1:0]   r3_p [3];
    logic signed [2*W+1:0]   r3_sum;
    logic signed [W:0]       r3_as [3];
    logic [W-1:0]            r3_abs [3];
    logic [2:0]              r3_neg;

    logic signed [2*W+1:0]   n_sum;
    logic signed [W-1:0]     as_sat [3];
    logic signed [W-1:0]     sc_sat [3];
    logic [2:0]              as_ovf;
    logic [2:0]              sc_ovf;
    logic signed [2*W+1:0]   dot_t;
    logic signed [2*W+1:0]   dot_r;
    logic signed [W-1:0]     dot_sat;
    logic                    dot_ovf;

    logic signed [W-1:0]     n_vec [3];
    logic signed [W-1:0]     n_sc;
    logic                    n_ovf;
    logic                    n_zn;

    logic                    r4_valid;
    t_kind                   r4_kind;
    logic                    r4_ovf;
    logic                    r4_zn;
    logic [2:0]              r4_neg;
    logic signed [W-1:0]     r4_vec [3];
    logic signed [W-1:0]     r4_sc;
    logic [W-1:0]            r4_abs [3];
    logic [2*W-1:0]          r4_sq;

    assign a_v[0] = i_ax;
    assign a_v[1] = i_ay;
    assign a_v[2] = i_az;
    assign b_v[0] = i_bx;
    assign b_v[1] = i_by;
    assign b_v[2] = i_bz;

    generate
        for (genvar g = 0; g < 3; g++) begin : g_lane
            logic signed [W-1:0]    m_in;
            logic signed [HW-1:0]   ah;
            logic signed [HW-1:0]   mh;
            logic [LW-1:0]          al;
            logic [LW-1:0]          ml;
            logic signed [2*HW-1:0] n_hh;
            logic signed [W:0]      n_hl;
            logic signed [W:0]      n_lh;
            logic [2*LW-1:0]        n_ll;
            logic signed [W:0]      n_as;
            logic [W-1:0]           n_abs;
            logic signed [2*W-1:0]  n_p;
            logic signed [2*W:0]    sc_t;
            logic signed [2*W:0]    sc_r;

            assign m_in = (i_kind == KIND_SCALE) ? i_scale_factor :
                          (i_kind == KIND_DOT)   ? b_v[g] : a_v[g];
            assign ah   = a_v[g][W-1:LW];
            assign al   = a_v[g][LW-1:0];
            assign mh   = m_in[W-1:LW];
            assign ml   = m_in[LW-1:0];
            assign n_hh = ah * mh;
            assign n_hl = ah * $signed({1'b0, ml});
            assign n_lh = $signed({1'b0, al}) * mh;
            assign n_ll = al * ml;
            assign n_as = (i_kind == KIND_SUB) ? ((W+1)'(a_v[g]) - (W+1)'(b_v[g]))
                                               : ((W+1)'(a_v[g]) + (W+1)'(b_v[g]));
            assign n_abs = a_v[g][W-1] ? W'(-a_v[g]) : a_v[g];

            assign n_p = ((2*W)'(r1_hh[g]) <<< (2*LW))
                       + ((2*W)'(r1_hl[g]) <<< LW)
                       + ((2*W)'(r1_lh[g]) <<< LW)
                       + $signed((2*W)'(r1_ll[g]));

            assign sc_t = (2*W+1)'(r3_p[g]) + HALF_P;
            assign sc_r = sc_t >>> F;

            v3a_sat #(.IW(2*W+1), .OW(W)) u_sat_sc (
                .i_val (sc_r),
                .o_val (sc_sat[g]),
                .o_ovf (sc_ovf[g])
            );

            v3a_sat #(.IW(W+1), .OW(W)) u_sat_as (
                .i_val (r3_as[g]),
                .o_val (as_sat[g]),
                .o_ovf (as_ovf[g])
            );

            always_ff @(posedge i_clk) begin
                r1_hh[g]  <= n_hh;
                r1_hl[g]  <= n_hl;
                r1_lh[g]  <= n_lh;
                r1_ll[g]  <= n_ll;
                r1_as[g]  <= n_as;
                r1_abs[g] <= n_abs;
                r2_p[g]   <= n_p;
                r2_as[g]  <= r1_as[g];
                r2_abs[g] <= r1_abs[g];
                r3_p[g]   <= r2_p[g];
                r3_as[g]  <= r2_as[g];
                r3_abs[g] <= r2_abs[g];
                r4_vec[g] <= n_vec[g];
                r4_abs[g] <= r3_abs[g];
            end
        end
    endgenerate

    assign n_sum = (2*W+2)'(r2_p[0]) + (2*W+2)'(r2_p[1]) + (2*W+2)'(r2_p[2]);
    assign dot_t = r3_sum + HALF_D;
    assign dot_r = dot_t >>> F;

    v3a_sat #(.IW(2*W+2), .OW(W)) u_sat_dot (
        .i_val (dot_r),
        .o_val (dot_sat),
        .o_ovf (dot_ovf)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vec[i] = '0;
        end
        n_sc  = '0;
        n_ovf = 1'b0;
        n_zn  = 1'b0;
        case (r3_kind)
            KIND_ADD, KIND_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_vec[i] = as_sat[i];
                end
                n_ovf = |as_ovf;
            end
            KIND_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_vec[i] = sc_sat[i];
                end
                n_ovf = |sc_ovf;
            end
            KIND_DOT: begin
                n_sc  = dot_sat;
                n_ovf = dot_ovf;
            end
            KIND_UNIT: begin
                n_zn = (r3_sum == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind <= t_kind'(i_kind);
        r1_neg  <= {i_az[W-1], i_ay[W-1], i_ax[W-1]};
        r2_kind <= r1_kind;
        r2_neg  <= r1_neg;
        r3_kind <= r2_kind;
        r3_neg  <= r2_neg;
        r3_sum  <= n_sum;
        r4_kind <= r3_kind;
        r4_neg  <= r3_neg;
        r4_ovf  <= n_ovf;
        r4_zn   <= n_zn;
        r4_sc   <= n_sc;
        r4_sq   <= r3_sum[2*W-1:0];
    end

    assign o_ctl  = '{valid: r4_valid, kind: r4_kind, ovf: r4_ovf, zn: r4_zn, neg: r4_neg};
    assign o_rx   = r4_vec[0];
    assign o_ry   = r4_vec[1];
    assign o_rz   = r4_vec[2];
    assign o_sc   = r4_sc;
    assign o_absa = {r4_abs[2], r4_abs[1], r4_abs[0]};
    assign o_sq   = r4_sq;

endmodule

>>> rtl/v3a_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module v3a_sqrt #(
    parameter int RW = 48,
    parameter int PW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [PW-1:0]     o_pay
);

    logic              r_valid [RW];
    logic [2*RW-1:0]   r_rad   [RW];
    logic [RW:0]       r_rem   [RW];
    logic [RW-1:0]     r_root  [RW];
    logic [PW-1:0]     r_pay   [RW];

    generate
        for (genvar k = 0; k < RW; k++) begin : g_stage
            logic            v_in;
            logic [2*RW-1:0] rad_in;
            logic [RW:0]     rem_in;
            logic [RW-1:0]   root_in;
            logic [PW-1:0]   pay_in;
            logic [RW+2:0]   cur;
            logic [RW+2:0]   trial;
            logic [RW+2:0]   diff;
            logic            ge;

            if (k == 0) begin : g_first
                assign v_in    = i_valid;
                assign rad_in  = i_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign pay_in  = i_pay;
            end else begin : g_next
                assign v_in    = r_valid[k-1];
                assign rad_in  = r_rad[k-1];
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign pay_in  = r_pay[k-1];
            end

            assign cur   = {rem_in, rad_in[2*RW-1 -: 2]};
            assign trial = {1'b0, root_in, 2'b01};
            assign ge    = (cur >= trial);
            assign diff  = cur - trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else begin
                    r_valid[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rad[k]  <= {rad_in[2*RW-3:0], 2'b00};
                r_rem[k]  <= ge ? diff[RW:0] : cur[RW:0];
                r_root[k] <= {root_in[RW-2:0], ge};
                r_pay[k]  <= pay_in;
            end
        end
    endgenerate

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_pay   = r_pay[RW-1];

endmodule

>>> rtl/v3a_div.sv
`timescale 1ns / 1ps
// Pipelined three-lane restoring divider for the unit-vector components.
module v3a_div #(
    parameter int AW = 32,
    parameter int RW = 48,
    parameter int SH = 33,
    parameter int QW = 18,
    parameter int PW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RW-1:0]     i_root,
    input  logic [3*AW-1:0]   i_absa,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [3*QW-1:0]   o_quo,
    output logic [PW-1:0]     o_pay
);

    localparam int NW = AW + SH + 1;

    logic              r0_valid;
    logic [RW:0]       r0_d;
    logic [RW:0]       r0_rem [3];
    logic [QW-1:0]     r0_nlo [3];
    logic [PW-1:0]     r0_pay;

    logic              r_valid [QW];
    logic [RW:0]       r_d     [QW];
    logic [PW-1:0]     r_pay   [QW];
    logic [RW:0]       r_rem   [QW][3];
    logic [QW-1:0]     r_nlo   [QW][3];
    logic [QW-1:0]     r_q     [QW][3];

    generate
        for (genvar g = 0; g < 3; g++) begin : g_setup
            logic [NW-1:0] num;
            assign num = (NW'(i_absa[g*AW +: AW]) << SH) + NW'(i_root);
            always_ff @(posedge i_clk) begin
                r0_rem[g] <= (RW+1)'(num[NW-1:QW]);
                r0_nlo[g] <= num[QW-1:0];
            end
        end

        for (genvar j = 0; j < QW; j++) begin : g_step
            logic          v_in;
            logic [RW:0]   d_in;
            logic [PW-1:0] pay_in;

            if (j == 0) begin : g_first
                assign v_in   = r0_valid;
                assign d_in   = r0_d;
                assign pay_in = r0_pay;
            end else begin : g_next
                assign v_in   = r_valid[j-1];
                assign d_in   = r_d[j-1];
                assign pay_in = r_pay[j-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_d[j]   <= d_in;
                r_pay[j] <= pay_in;
            end

            for (genvar g = 0; g < 3; g++) begin : g_lane
                logic [RW:0]   rem_in;
                logic [QW-1:0] nlo_in;
                logic [QW-1:0] q_in;
                logic [RW+1:0] cur;
                logic [RW+1:0] dd;
                logic [RW+1:0] diff;
                logic          ge;

                if (j == 0) begin : g_first
                    assign rem_in = r0_rem[g];
                    assign nlo_in = r0_nlo[g];
                    assign q_in   = '0;
                end else begin : g_next
                    assign rem_in = r_rem[j-1][g];
                    assign nlo_in = r_nlo[j-1][g];
                    assign q_in   = r_q[j-1][g];
                end

                assign cur  = {rem_in, nlo_in[QW-1]};
                assign dd   = {1'b0, d_in};
                assign ge   = (cur >= dd);
                assign diff = cur - dd;

                always_ff @(posedge i_clk) begin
                    r_rem[j][g] <= ge ? diff[RW:0] : cur[RW:0];
                    r_nlo[j][g] <= {nlo_in[QW-2:0], 1'b0};
                    r_q[j][g]   <= {q_in[QW-2:0], ge};
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_d   <= {i_root, 1'b0};
        r0_pay <= i_pay;
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = {r_q[QW-1][2], r_q[QW-1][1], r_q[QW-1][0]};
    assign o_pay   = r_pay[QW-1];

endmodule

>>> rtl/vec3_fixed_point_alu_top.sv
`timescale 1ns / 1ps
// Top level of the three-component fixed-point vector ALU.
// One word is taken in every clock cycle and busy never rises. Every operation runs through
// the same chain of stages, from the edge that takes start to the edge that takes the result
// marked by o_done, so results leave in the order the words came in, one per cycle at most.
// The depth is set by the square root, one root bit per stage over DATA_WIDTH + FRAC_BITS
// stages, and the unit-vector divider, one setup stage and one quotient bit per stage over
// FRAC_BITS + 2 stages; four front stages hold the split multipliers and the sums, and one
// output register follows the divider. Each result is shown for exactly one cycle and cannot
// be held off.
module vec3_fixed_point_alu_top
    import v3a_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_kind,
    input  logic signed [DATA_WIDTH-1:0]   i_ax,
    input  logic signed [DATA_WIDTH-1:0]   i_ay,
    input  logic signed [DATA_WIDTH-1:0]   i_az,
    input  logic signed [DATA_WIDTH-1:0]   i_bx,
    input  logic signed [DATA_WIDTH-1:0]   i_by,
    input  logic signed [DATA_WIDTH-1:0]   i_bz,
    input  logic signed [DATA_WIDTH-1:0]   i_scale_factor,
    output logic                           o_done,
    output logic signed [DATA_WIDTH-1:0]   o_rx,
    output logic signed [DATA_WIDTH-1:0]   o_ry,
    output logic signed [DATA_WIDTH-1:0]   o_rz,
    output logic signed [DATA_WIDTH-1:0]   o_scalar_out,
    output logic                           o_overflow,
    output logic                           o_zero_norm
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RW   = W + F;
    localparam int QW   = F + 2;
    localparam int SP_W = CTL_W + 7 * W;
    localparam int DP_W = CTL_W + 5 * W + 1;
    localparam logic [RW:0] HALF_N = {{(RW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    t_ctl                f_ctl;
    logic signed [W-1:0] f_rx;
    logic signed [W-1:0] f_ry;
    logic signed [W-1:0] f_rz;
    logic signed [W-1:0] f_sc;
    logic [3*W-1:0]      f_absa;
    logic [2*W-1:0]      f_sq;

    logic                s_valid;
    logic [RW-1:0]       s_root;
    logic [SP_W-1:0]     s_pay;
    logic [RW:0]         s_norm_t;
    logic signed [W+1:0] s_norm_v;
    logic signed [W-1:0] s_norm;
    logic                s_norm_ovf;

    logic                d_valid;
    logic [3*QW-1:0]     d_quo;
    logic [DP_W-1:0]     d_pay;
    t_ctl                d_ctl;
    logic signed [W-1:0] d_rx;
    logic signed [W-1:0] d_ry;
    logic signed [W-1:0] d_rz;
    logic signed [W-1:0] d_sc;
    logic signed [W-1:0] d_norm;
    logic                d_novf;
    logic signed [W-1:0] u_sat [3];
    logic [2:0]          u_ovf;

    logic signed [W-1:0] n_rx;
    logic signed [W-1:0] n_ry;
    logic signed [W-1:0] n_rz;
    logic signed [W-1:0] n_sc;
    logic                n_ovf;
    logic                n_zn;

    logic                r_done;
    logic signed [W-1:0] r_rx;
    logic signed [W-1:0] r_ry;
    logic signed [W-1:0] r_rz;
    logic signed [W-1:0] r_sc;
    logic                r_ovf;
    logic                r_zn;

    assign busy = 1'b0;

    v3a_front #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start & ~busy),
        .i_kind         (i_kind),
        .i_ax           (i_ax),
        .i_ay           (i_ay),
        .i_az           (i_az),
        .i_bx           (i_bx),
        .i_by           (i_by),
        .i_bz           (i_bz),
        .i_scale_factor (i_scale_factor),
        .o_ctl          (f_ctl),
        .o_rx           (f_rx),
        .o_ry           (f_ry),
        .o_rz           (f_rz),
        .o_sc           (f_sc),
        .o_absa         (f_absa),
        .o_sq           (f_sq)
    );

    v3a_sqrt #(.RW(RW), .PW(SP_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_ctl.valid),
        .i_rad   ({f_sq, {(2*F){1'b0}}}),
        .i_pay   ({f_ctl, f_rx, f_ry, f_rz, f_sc, f_absa}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_pay   (s_pay)
    );

    assign s_norm_t = (RW+1)'(s_root) + HALF_N;
    assign s_norm_v = $signed({1'b0, s_norm_t[RW:F]});

    v3a_sat #(.IW(W+2), .OW(W)) u_sat_norm (
        .i_val (s_norm_v),
        .o_val (s_norm),
        .o_ovf (s_norm_ovf)
    );

    v3a_div #(.AW(W), .RW(RW), .SH(2*F+1), .QW(QW), .PW(DP_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_absa  (s_pay[3*W-1:0]),
        .i_pay   ({s_pay[SP_W-1:3*W], s_norm, s_norm_ovf}),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_pay   (d_pay)
    );

    assign d_ctl  = d_pay[DP_W-1 -: CTL_W];
    assign d_rx   = d_pay[5*W -: W];
    assign d_ry   = d_pay[4*W -: W];
    assign d_rz   = d_pay[3*W -: W];
    assign d_sc   = d_pay[2*W -: W];
    assign d_norm = d_pay[W -: W];
    assign d_novf = d_pay[0];

    generate
        for (genvar g = 0; g < 3; g++) begin : g_unit
            logic signed [QW:0] u_mag;
            logic signed [QW:0] u_val;
            assign u_mag = $signed({1'b0, d_quo[g*QW +: QW]});
            assign u_val = d_ctl.neg[g] ? -u_mag : u_mag;
            v3a_sat #(.IW(QW+1), .OW(W)) u_sat_unit (
                .i_val (u_val),
                .o_val (u_sat[g]),
                .o_ovf (u_ovf[g])
            );
        end
    endgenerate

    always_comb begin
        n_rx  = d_rx;
        n_ry  = d_ry;
        n_rz  = d_rz;
        n_sc  = d_sc;
        n_ovf = d_ctl.ovf;
        n_zn  = 1'b0;
        case (d_ctl.kind)
            KIND_NORM: begin
                n_sc  = d_norm;
                n_ovf = d_novf;
            end
            KIND_UNIT: begin
                if (d_ctl.zn) begin
                    n_rx  = '0;
                    n_ry  = '0;
                    n_rz  = '0;
                    n_ovf = 1'b0;
                    n_zn  = 1'b1;
                end else begin
                    n_rx  = u_sat[0];
                    n_ry  = u_sat[1];
                    n_rz  = u_sat[2];
                    n_ovf = |u_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_zn   <= 1'b0;
        end else begin
            r_done <= d_valid;
            r_zn   <= n_zn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx  <= n_rx;
        r_ry  <= n_ry;
        r_rz  <= n_rz;
        r_sc  <= n_sc;
        r_ovf <= n_ovf;
    end

    assign o_done       = r_done;
    assign o_rx         = r_rx;
    assign o_ry         = r_ry;
    assign o_rz         = r_rz;
    assign o_scalar_out = r_sc;
    assign o_overflow   = r_ovf;
    assign o_zero_norm  = r_zn;

endmodule

>>> rtl/v3a_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the vector ALU top level and their binding.
module v3a_checker #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic signed [DATA_WIDTH-1:0] o_rx,
    input logic signed [DATA_WIDTH-1:0] o_ry,
    input logic signed [DATA_WIDTH-1:0] o_rz,
    input logic signed [DATA_WIDTH-1:0] o_scalar_out,
    input logic                         o_overflow,
    input logic                         o_zero_norm
);

    localparam int LAT = 8 + DATA_WIDTH + 2 * FRAC_BITS;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("word taken but no result after the pipeline latency");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_norm) |-> (!o_overflow && o_rx == 0 && o_ry == 0
                                     && o_rz == 0 && o_scalar_out == 0))
        else $error("zero-length flag with a nonzero result");

    a_scalar_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scalar_out != 0) |-> (o_rx == 0 && o_ry == 0 && o_rz == 0))
        else $error("scalar result together with a vector result");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a fully pipelined unit");

endmodule

bind vec3_fixed_point_alu_top v3a_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_v3a_checker (.*);
